// ----- design/bfd_pkg.sv -----
package bfd_pkg;

	// frame size limit and derived widths
	localparam int MAX_DIM = 4096;
	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int REG_W = DIM_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CH_W = 8;
	localparam int CHANNELS = 4;
	localparam int PIX_W = CH_W * CHANNELS;
	localparam int SUM_W = CH_W + 2 * DIM_W;
	localparam int DIVW = SUM_W + 1;
	localparam int CNT_W = 2 * DIM_W + 1;
	localparam int SCALE_STEPS = REG_W;
	localparam int SC_W = $clog2(SCALE_STEPS);
	localparam int QUO_W = CH_W;
	localparam int BIT_W = $clog2(QUO_W);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SCALE,
		S_FIN,
		S_IDLE,
		S_ACC,
		S_DIV,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scale_start;
		logic scale_step;
		logic scale_fin;
		logic acc;
		logic div_step;
		logic out_load;
	} bfd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cfg_hit;
		logic emit;
		logic bad;
		logic scale_done;
		logic div_done;
		logic out_free;
	} bfd_sts_t;

endpackage

// ----- design/bfd_ctrl.sv -----
module bfd_ctrl
	import bfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  bfd_sts_t sts,
	output bfd_cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (sts.cfg_hit) begin
			state_d = S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: state_d = S_SCALE;
				S_SCALE: begin
					if (sts.scale_done) state_d = S_FIN;
				end
				S_FIN: state_d = S_IDLE;
				S_IDLE: begin
					if (s_tvalid) state_d = S_ACC;
				end
				S_ACC: begin
					if (!sts.emit) state_d = S_IDLE;
					else if (sts.bad) state_d = S_EMIT;
					else state_d = S_DIV;
				end
				S_DIV: begin
					if (sts.div_done) state_d = S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) state_d = S_IDLE;
				end
				default: state_d = S_LOAD;
			endcase
		end
	end

	// command outputs
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_LOAD: cmd.scale_start = 1'b1;
			S_SCALE: cmd.scale_step = 1'b1;
			S_FIN: cmd.scale_fin = 1'b1;
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
			end
			S_ACC: cmd.acc = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_EMIT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_acc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !sts.cfg_hit |=> state_q == S_ACC)
		else $error("accepted item not followed by accumulate");

	a_div_stay: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !sts.div_done && !sts.cfg_hit |=> state_q == S_DIV)
		else $error("average division left early");

	a_emit_leave: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && sts.out_free && !sts.cfg_hit |=> state_q == S_IDLE)
		else $error("result load did not return to idle");

endmodule

// ----- design/bfd_datapath.sv -----
module bfd_datapath
	import bfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfd_cmd_t             cmd,
	output bfd_sts_t             sts,
	input  logic [PIX_W-1:0]     s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
		if (v == '0) return REG_W'(1);
		else if (v > REG_W'(MAX_DIM)) return REG_W'(MAX_DIM);
		else return v;
	endfunction

	logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [REG_W-1:0] eff_w, eff_h;
	logic             bad_c, bad_q, cfg_hit;
	logic [REG_W-1:0] sx_q, sy_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DIM_W-1:0] col_q, row_q, subc_q, subr_q, dc_q, dr_q;
	logic             col_end, row_end, subc_end, subr_end;
	logic             in_range, blk_end, fresh, last_dst, last_src;

	logic [PIX_W-1:0]       pix_s1;
	logic [DIM_W-1:0]       addr_s1;
	logic                   fresh_s1, emit_s1, acc_s1, last_s1;
	logic [CHANNELS*SUM_W-1:0] mem [MAX_DIM];
	logic [CHANNELS*SUM_W-1:0] rd_q, wr_data;

	logic [REG_W-1:0] sq_q [2];
	logic [REG_W-1:0] sr_q [2];
	logic [REG_W-1:0] sq_d [2];
	logic [REG_W-1:0] sr_d [2];
	logic [REG_W-1:0] dvd [2];
	logic [REG_W-1:0] dvs [2];
	logic [SC_W-1:0]  sc_q;
	logic [2*REG_W-1:0] prod;

	logic [SUM_W-1:0] rem_q [CHANNELS];
	logic [SUM_W-1:0] rem_d [CHANNELS];
	logic [QUO_W-1:0] quo_q [CHANNELS];
	logic             qbit [CHANNELS];
	logic [BIT_W-1:0] bit_q;
	logic [DIVW-1:0]  div_shift;

	logic             m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [PIX_W-1:0] m_tdata_q;

	// configuration decode
	always_comb begin
		unique case (cfg_index)
			CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT: cfg_hit = cfg_wen;
			default: cfg_hit = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= REG_W'(1);
			src_h_q <= REG_W'(1);
			dst_w_q <= REG_W'(1);
			dst_h_q <= REG_W'(1);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH: src_w_q <= cfg_data;
				CFG_SRC_HEIGHT: src_h_q <= cfg_data;
				CFG_DST_WIDTH: dst_w_q <= cfg_data;
				CFG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = clamp_dim(src_w_q);
	assign eff_h = clamp_dim(src_h_q);
	assign bad_c = dst_w_q == '0 || dst_h_q == '0 || dst_w_q > eff_w || dst_h_q > eff_h;

	// scale dividers: restoring, one quotient bit per cycle, width and height together
	assign dvd[0] = eff_w;
	assign dvd[1] = eff_h;
	assign dvs[0] = dst_w_q;
	assign dvs[1] = dst_h_q;

	always_comb begin
		logic [REG_W:0] t;
		t = '0;
		for (int k = 0; k < 2; k++) begin
			t = {sr_q[k], sq_q[k][REG_W-1]};
			if (t >= {1'b0, dvs[k]}) begin
				sr_d[k] = REG_W'(t - {1'b0, dvs[k]});
				sq_d[k] = {sq_q[k][REG_W-2:0], 1'b1};
			end else begin
				sr_d[k] = t[REG_W-1:0];
				sq_d[k] = {sq_q[k][REG_W-2:0], 1'b0};
			end
		end
	end

	assign prod = sq_q[0] * sq_q[1];

	always_ff @(posedge clk) begin
		if (cmd.scale_start) begin
			for (int k = 0; k < 2; k++) begin
				sq_q[k] <= dvd[k];
				sr_q[k] <= '0;
			end
			sc_q <= SC_W'(SCALE_STEPS - 1);
		end else if (cmd.scale_step) begin
			for (int k = 0; k < 2; k++) begin
				sq_q[k] <= sq_d[k];
				sr_q[k] <= sr_d[k];
			end
			sc_q <= sc_q - SC_W'(1);
		end
		if (cmd.scale_fin) begin
			bad_q <= bad_c;
			sx_q <= bad_c ? REG_W'(1) : sq_q[0];
			sy_q <= bad_c ? REG_W'(1) : sq_q[1];
			cnt_q <= bad_c ? CNT_W'(1) : CNT_W'(prod);
		end
	end

	// position in the source frame and in the destination grid
	assign col_end = REG_W'(col_q) + REG_W'(1) >= eff_w;
	assign row_end = REG_W'(row_q) + REG_W'(1) >= eff_h;
	assign subc_end = REG_W'(subc_q) + REG_W'(1) == sx_q;
	assign subr_end = REG_W'(subr_q) + REG_W'(1) == sy_q;
	assign in_range = REG_W'(dc_q) < dst_w_q && REG_W'(dr_q) < dst_h_q;
	assign blk_end = subc_end && subr_end;
	assign fresh = subc_q == '0 && subr_q == '0;
	assign last_dst = REG_W'(dc_q) + REG_W'(1) == dst_w_q &&
		REG_W'(dr_q) + REG_W'(1) == dst_h_q;
	assign last_src = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			subc_q <= '0;
			subr_q <= '0;
			dc_q <= '0;
			dr_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
			subc_q <= '0;
			subr_q <= '0;
			dc_q <= '0;
			dr_q <= '0;
		end else if (cmd.accept) begin
			if (col_end) begin
				col_q <= '0;
				subc_q <= '0;
				dc_q <= '0;
				if (row_end) begin
					row_q <= '0;
					subr_q <= '0;
					dr_q <= '0;
				end else begin
					row_q <= row_q + DIM_W'(1);
					if (subr_end) begin
						subr_q <= '0;
						dr_q <= dr_q + DIM_W'(1);
					end else begin
						subr_q <= subr_q + DIM_W'(1);
					end
				end
			end else begin
				col_q <= col_q + DIM_W'(1);
				if (subc_end) begin
					subc_q <= '0;
					dc_q <= dc_q + DIM_W'(1);
				end else begin
					subc_q <= subc_q + DIM_W'(1);
				end
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_s1 <= s_tdata;
			addr_s1 <= dc_q;
			fresh_s1 <= fresh;
			acc_s1 <= !bad_q && in_range;
			emit_s1 <= bad_q ? last_src : (in_range && blk_end);
			last_s1 <= last_dst;
		end
	end

	// new column sums; the first pixel of a block starts from zero
	always_comb begin
		logic [SUM_W-1:0] old;
		old = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			old = fresh_s1 ? '0 : rd_q[k*SUM_W +: SUM_W];
			wr_data[k*SUM_W +: SUM_W] = old + SUM_W'(pix_s1[k*CH_W +: CH_W]);
		end
	end

	// column sum memory
	always_ff @(posedge clk) begin
		if (cmd.acc && acc_s1) mem[addr_s1] <= wr_data;
		if (cmd.accept) rd_q <= mem[dc_q];
	end

	// average division: restoring, one quotient bit per cycle on all channels
	assign div_shift = DIVW'(cnt_q) << bit_q;

	always_comb begin
		logic [DIVW-1:0] trial;
		trial = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			trial = {1'b0, rem_q[k]} - div_shift;
			qbit[k] = !trial[DIVW-1];
			rem_d[k] = qbit[k] ? trial[SUM_W-1:0] : rem_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			for (int k = 0; k < CHANNELS; k++) begin
				rem_q[k] <= wr_data[k*SUM_W +: SUM_W];
			end
			bit_q <= BIT_W'(QUO_W - 1);
		end else if (cmd.div_step) begin
			for (int k = 0; k < CHANNELS; k++) begin
				rem_q[k] <= rem_d[k];
				quo_q[k] <= {quo_q[k][QUO_W-2:0], qbit[k]};
			end
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= bad_q ? '0 : {quo_q[3], quo_q[2], quo_q[1], quo_q[0]};
			m_tlast_q <= bad_q ? 1'b1 : last_s1;
			m_tuser_q <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	// status to the controller
	assign sts.cfg_hit = cfg_hit;
	assign sts.emit = emit_s1;
	assign sts.bad = bad_q;
	assign sts.scale_done = sc_q == '0;
	assign sts.div_done = bit_q == '0;
	assign sts.out_free = !m_tvalid_q || m_tready;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("size error item carries pixel data");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten before taken");

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scale_fin |=> cnt_q != '0)
		else $error("block pixel count is zero");

endmodule

// ----- design/box_filter_downscaler.sv -----
// Box filter downscaler: takes 32-bit ARGB pixels (alpha in bits 31:24) of a source frame in
// raster order and emits the per-channel truncated average of each sx by sy block, with
// sx = src_width / dst_width and sy = src_height / dst_height; source pixels right of or below
// the covered area give no item, and an upscale or zero destination size gives one error item
// (tuser high, tlast high, data zero) on the last source pixel of each frame. Configuration
// registers are indexed 0 src_width, 1 src_height, 2 dst_width, 3 dst_height; any write to one
// of them restarts the frame. After reset and after each such write the block computes the
// scales with two 13-step restoring dividers, width and height together, with s_tready low.
// Then an item that adds to a column sum goes through the column sum memory read and the
// write-back; an item that completes a block also goes through an eight-step restoring divider
// that forms all four channel averages, and an error item goes straight to the output
// register. The result sits in an output register, so the next pixel is taken while it waits;
// the block stalls only when a new result is ready and the previous one has not been taken.
module box_filter_downscaler
	import bfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,    // pixel_in[31:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,    // pixel_out[31:0]
	output logic                 m_tlast,    // frame_done
	output logic                 m_tuser,    // size_error
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	bfd_cmd_t cmd;
	bfd_sts_t sts;

	// sequencer
	bfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// sums, dividers and output register
	bfd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ----- tb/tb.sv -----
module tb;
	import bfd_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_WAIT = 5;

	// register indexes past the four real ones
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             done;
		logic             err;
	} dst_pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata = '0;    // pixel_in[31:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [PIX_W-1:0]     m_tdata;         // pixel_out[31:0]
	logic                 m_tlast;         // frame_done
	logic                 m_tuser;         // size_error
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	box_filter_downscaler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// downscaler state as the testbench sees it
	logic [REG_W-1:0] src_w, src_h, dst_w, dst_h;
	longint unsigned  chan_sum [CHANNELS][MAX_DIM];
	int               src_col, src_row;
	int               eff_w, eff_h;
	int               scale_x, scale_y;
	bit               size_bad;

	logic [PIX_W-1:0] pixel_backlog [$];
	dst_pixel_t       pending_dst_pixels [$];
	int               pixels_queued = 0;
	int               pixels_taken = 0;
	int               fail_count = 0;
	int               feed_gap = 0;
	int               out_hold = 0;
	int               cycle_count = 0;
	bit               feed_steady = 1'b0;
	bit               drain_steady = 1'b0;

	function automatic int clamp_dim(input logic [REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// any write to one of the four size registers restarts the frame and recomputes the scales
	task automatic restart_frame();
		for (int ch = 0; ch < CHANNELS; ch++)
			for (int c = 0; c < MAX_DIM; c++)
				chan_sum[ch][c] = 0;
		src_col = 0;
		src_row = 0;
		eff_w = clamp_dim(src_w);
		eff_h = clamp_dim(src_h);
		size_bad = dst_w == 0 || dst_h == 0 || dst_w > eff_w || dst_h > eff_h;
		if (size_bad) begin
			scale_x = 1;
			scale_y = 1;
		end else begin
			scale_x = eff_w / int'(dst_w);
			scale_y = eff_h / int'(dst_h);
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		case (idx)
			CFG_SRC_WIDTH: src_w = value;
			CFG_SRC_HEIGHT: src_h = value;
			CFG_DST_WIDTH: dst_w = value;
			CFG_DST_HEIGHT: dst_h = value;
			default: return;
		endcase
		restart_frame();
	endtask

	// adds one source pixel to its column sums, emits the average when a block closes
	task automatic accumulate_source_pixel(input logic [PIX_W-1:0] px);
		int              dc, dr;
		longint unsigned cnt;
		dst_pixel_t      res;
		if (size_bad) begin
			if (src_col + 1 >= eff_w && src_row + 1 >= eff_h) begin
				res.pixel = '0;
				res.done = 1'b1;
				res.err = 1'b1;
				pending_dst_pixels.push_back(res);
			end
		end else begin
			dc = src_col / scale_x;
			dr = src_row / scale_y;
			if (dc < dst_w && dr < dst_h && dc < MAX_DIM) begin
				for (int ch = 0; ch < CHANNELS; ch++)
					chan_sum[ch][dc] += px[ch*CH_W +: CH_W];
				if (src_col % scale_x == scale_x - 1 && src_row % scale_y == scale_y - 1) begin
					cnt = longint'(scale_x) * scale_y;
					for (int ch = 0; ch < CHANNELS; ch++) begin
						res.pixel[ch*CH_W +: CH_W] = CH_W'(chan_sum[ch][dc] / cnt);
						chan_sum[ch][dc] = 0;
					end
					res.done = (dc + 1 == dst_w) && (dr + 1 == dst_h);
					res.err = 1'b0;
					pending_dst_pixels.push_back(res);
				end
			end
		end
		src_col++;
		if (src_col >= eff_w) begin
			src_col = 0;
			src_row++;
			if (src_row >= eff_h)
				src_row = 0;
		end
	endtask

	// pixel source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			feed_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				accumulate_source_pixel(s_tdata);
				pixels_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (feed_gap > 0) begin
					feed_gap <= feed_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pixel_backlog.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pixel_backlog.pop_front();
					feed_gap <= feed_steady ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: check each item, then stall a random while
	always @(posedge clk or negedge arst_n) begin : result_check
		dst_pixel_t want;
		int         hold;
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_hold <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_dst_pixels.size() == 0) begin
					$error("unexpected item: pixel_out %h frame_done %b size_error %b",
						m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					want = pending_dst_pixels.pop_front();
					if (m_tdata !== want.pixel) begin
						$error("pixel_out: expected %h, got %h", want.pixel, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.done) begin
						$error("frame_done: expected %b, got %b", want.done, m_tlast);
						fail_count++;
					end
					if (m_tuser !== want.err) begin
						$error("size_error: expected %b, got %b", want.err, m_tuser);
						fail_count++;
					end
				end
				hold = drain_steady ? 0 : $urandom_range(0, MAX_WAIT);
				out_hold <= hold;
				m_tready <= (hold == 0);
			end else if (!m_tready) begin
				if (out_hold <= 1)
					m_tready <= 1'b1;
				out_hold <= out_hold - 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_pixel(input logic [PIX_W-1:0] px);
		pixel_backlog.push_back(px);
		pixels_queued++;
	endtask

	// wait until every pixel is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (pixels_taken != pixels_queued || pending_dst_pixels.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		apply_reg(idx, value);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// quiet the block, then write all four sizes in a randomly rotated order
	task automatic configure_frame(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
			input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh);
		logic [CFG_IDX_W-1:0] order [4];
		logic [REG_W-1:0]     vals [4];
		int                   rot;
		order = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT};
		vals = '{sw, sh, dw, dh};
		rot = $urandom_range(0, 3);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int k = 0; k < 4; k++)
			write_reg(order[(rot + k) % 4], vals[(rot + k) % 4]);
		feed_steady = ($urandom_range(0, 3) == 0);
		drain_steady = ($urandom_range(0, 3) == 0);
	endtask

	// biased toward saturated channels so sums and truncation get stressed
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] px;
		case ($urandom_range(0, 9))
			0: px = '0;
			1: px = '1;
			2: begin
				for (int ch = 0; ch < CHANNELS; ch++)
					px[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			end
			default: px = $urandom;
		endcase
		return px;
	endfunction

	task automatic queue_random_pixels(input int count);
		for (int i = 0; i < count; i++)
			queue_pixel(pick_pixel());
	endtask

	initial begin : stimulus
		int               random_sent;
		int               area, count, half;
		logic [REG_W-1:0] sw, sh, dw, dh;

		src_w = 1;
		src_h = 1;
		dst_w = 1;
		dst_h = 1;
		restart_frame();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes pass pixels through
		queue_pixel('0);
		queue_pixel('1);
		queue_pixel(32'ha5a5a5a5);
		queue_pixel(32'h5a5a5a5a);

		// writes to unused indexes change nothing
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
			write_reg(CFG_IDX_W'(i), '1);
		queue_pixel(32'h01234567);

		// 2x2 blocks, truncating averages, with a full pause mid-frame
		configure_frame(4, 2, 2, 1);
		queue_pixel('1);
		queue_pixel('1);
		queue_pixel(32'h01020304);
		queue_pixel(32'h00000001);
		drain();
		queue_pixel('1);
		queue_pixel('0);
		queue_pixel(32'h03030303);
		queue_pixel(32'hff000000);

		// zero destination size: every pixel closes a 1x1 frame in error
		configure_frame(1, 1, 0, 0);
		queue_pixel('1);
		queue_pixel('0);

		// upscale request: one error item at the end of the frame
		configure_frame(3, 2, 4, 1);
		queue_random_pixels(6);

		// trailing column outside the covered area
		configure_frame(5, 2, 2, 1);
		queue_random_pixels(10);

		// random frames, mostly small so whole frames complete
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			sw = REG_W'($urandom_range(1, 16));
			sh = REG_W'($urandom_range(1, 6));
			dw = REG_W'($urandom_range(1, sw));
			dh = REG_W'($urandom_range(1, sh));
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: dw = 0;
					1: dh = 0;
					2: dw = sw + REG_W'($urandom_range(1, 3));
					default: dh = sh + REG_W'($urandom_range(1, 3));
				endcase
			end
			if ($urandom_range(0, 15) == 0)
				sw = 0;
			configure_frame(sw, sh, dw, dh);
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_SPARE_FIRST, REG_W'($urandom));
			area = eff_w * eff_h;
			count = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
			if ($urandom_range(0, 3) == 0) begin
				half = count / 2;
				queue_random_pixels(half);
				drain();
				queue_random_pixels(count - half);
			end else begin
				queue_random_pixels(count);
			end
			random_sent += count;
		end

		// widest frame passed through
		configure_frame('1, 1, REG_W'(MAX_DIM), 1);
		queue_random_pixels(24);

		// whole frame averaged into one pixel
		configure_frame(64, 4, 1, 1);
		queue_random_pixels(256);

		// tallest frame, single column
		configure_frame(1, '1, 1, REG_W'(MAX_DIM));
		queue_random_pixels(20);

		// zero source sizes act as one
		configure_frame(0, 0, 1, 1);
		queue_random_pixels(3);

		// destination width far beyond the source
		configure_frame(2, 2, '1, 1);
		queue_random_pixels(8);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- box_filter_downscaler.f -----
design/bfd_pkg.sv
design/bfd_ctrl.sv
design/bfd_datapath.sv
design/box_filter_downscaler.sv
tb/tb.sv
